FILE: hdl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// shared widths, the cell state type and a rotate helper for speck 48/72
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int WORD_W     = 24;
  localparam int NUM_ROUNDS = 22;
  localparam int ROUND_W    = $clog2(NUM_ROUNDS);

  // rotate amounts of the round function
  localparam int ROT_A     = 16;  // rotate right by 8
  localparam int ROT_B     = 3;
  localparam int ROT_B_INV = 21;  // rotate right by 3
  localparam int ROT_A_INV = 8;

  // operation carried with each word
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } cipher_op_e;

  // everything one cell hands to the next
  typedef struct packed {
    logic              op;   // 0 encrypt, 1 decrypt
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] k;    // current round key
    logic [WORD_W-1:0] la;   // schedule word used next
    logic [WORD_W-1:0] lb;   // schedule word used after that
  } spk_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned        n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

FILE: hdl/spk_fwd_cell.sv
// ----------------------------------------------------------------------------
// spk_fwd_cell
// one forward round: encrypt words encrypted; unless last, one schedule step
// ----------------------------------------------------------------------------
module spk_fwd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [spk_pkg::ROUND_W-1:0] round_i,
  input  logic                       valid_i,
  input  spk_pkg::spk_state_t        state_i,
  output logic                       valid_o,
  output spk_pkg::spk_state_t        state_o
);
  import spk_pkg::*;

  logic              valid_q;
  spk_state_t        state_q, state_d;
  logic [WORD_W-1:0] x_new, ln;
  logic              last;

  assign last = (round_i == ROUND_W'(NUM_ROUNDS - 1));

  always_comb begin
    state_d = state_i;
    x_new   = (rotl(state_i.x, ROT_A) + state_i.y) ^ state_i.k;
    ln      = (rotl(state_i.la, ROT_A) + state_i.k) ^ WORD_W'(round_i);
    if (state_i.op == OP_ENCRYPT) begin
      state_d.x = x_new;
      state_d.y = rotl(state_i.y, ROT_B) ^ x_new;
    end
    // last cell keeps the final round key for the reverse chain
    if (!last) begin
      state_d.k  = rotl(state_i.k, ROT_B) ^ ln;
      state_d.la = state_i.lb;
      state_d.lb = ln;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

FILE: hdl/spk_bwd_cell.sv
// ----------------------------------------------------------------------------
// spk_bwd_cell
// one reverse round: decrypts decrypt words; round > 0 steps key schedule back
// ----------------------------------------------------------------------------
module spk_bwd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [spk_pkg::ROUND_W-1:0] round_i,
  input  logic                       valid_i,
  input  spk_pkg::spk_state_t        state_i,
  output logic                       valid_o,
  output spk_pkg::spk_state_t        state_o
);
  import spk_pkg::*;

  logic              valid_q;
  spk_state_t        state_q, state_d;
  logic [WORD_W-1:0] y_new, k_old;
  logic [ROUND_W-1:0] round_prev;

  assign round_prev = round_i - ROUND_W'(1);

  always_comb begin
    state_d = state_i;
    y_new   = rotl(state_i.y ^ state_i.x, ROT_B_INV);
    k_old   = rotl(state_i.k ^ state_i.lb, ROT_B_INV);
    if (state_i.op == OP_DECRYPT) begin
      state_d.y = y_new;
      state_d.x = rotl((state_i.x ^ state_i.k) - y_new, ROT_A_INV);
    end
    // undo the schedule step that made this round key
    if (round_i != '0) begin
      state_d.k  = k_old;
      state_d.la = rotl((state_i.lb ^ WORD_W'(round_prev)) - k_old, ROT_A_INV);
      state_d.lb = state_i.la;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

  // encrypt words pass the reverse chain untouched
  a_enc_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (state_q.op == OP_ENCRYPT)) |->
      (state_q.x == $past(state_i.x)) && (state_q.y == $past(state_i.y)))
    else $error("encrypt word altered in reverse cell");

endmodule

FILE: hdl/speck48_72_cipher.sv
// ----------------------------------------------------------------------------
// speck48_72_cipher
// speck 48/72 encrypt / decrypt as a chain of round cells, one word per clock
// ----------------------------------------------------------------------------
// every word, encrypt or decrypt alike, passes the 22 forward cells and then
//   the 22 reverse cells before its done_o cycle
// throughput: one word per cycle; busy stays low, start is taken every cycle
// the receiver cannot stall: each result shows on out_*_o for one done_o cycle
// reset (rst_ni low, asynchronous) clears every cell's valid bit, so words in
//   flight are dropped; data registers are not reset
module speck48_72_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode_i,
  input  logic [spk_pkg::WORD_W-1:0] block_x_i,
  input  logic [spk_pkg::WORD_W-1:0] block_y_i,
  input  logic [spk_pkg::WORD_W-1:0] key_first_round_i,
  input  logic [spk_pkg::WORD_W-1:0] key_sched_a_i,
  input  logic [spk_pkg::WORD_W-1:0] key_sched_b_i,
  output logic                      done_o,
  output logic [spk_pkg::WORD_W-1:0] out_x_o,
  output logic [spk_pkg::WORD_W-1:0] out_y_o
);
  import spk_pkg::*;

  // forward chain: encrypt rounds for encrypt words, and for every word the
  // key schedule runs up to the last round key.
  // reverse chain: decrypt rounds last key first, with the schedule run
  // backwards (it is invertible), so no round key table is needed.
  logic       fwd_v [NUM_ROUNDS+1];
  spk_state_t fwd_s [NUM_ROUNDS+1];
  logic       bwd_v [NUM_ROUNDS+1];
  spk_state_t bwd_s [NUM_ROUNDS+1];

  // never stalls: a new word can enter every cycle
  assign busy = 1'b0;

  assign fwd_v[0]    = start && !busy;
  assign fwd_s[0].op = opcode_i;
  assign fwd_s[0].x  = block_x_i;
  assign fwd_s[0].y  = block_y_i;
  assign fwd_s[0].k  = key_first_round_i;
  assign fwd_s[0].la = key_sched_a_i;
  assign fwd_s[0].lb = key_sched_b_i;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_fwd
    spk_fwd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (ROUND_W'(r)),
      .valid_i (fwd_v[r]),
      .state_i (fwd_s[r]),
      .valid_o (fwd_v[r+1]),
      .state_o (fwd_s[r+1])
    );
  end

  // hand over: key state now holds the last round key
  assign bwd_v[0] = fwd_v[NUM_ROUNDS];
  assign bwd_s[0] = fwd_s[NUM_ROUNDS];

  // reverse cell j undoes round NUM_ROUNDS-1-j
  for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_bwd
    spk_bwd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (ROUND_W'(NUM_ROUNDS - 1 - j)),
      .valid_i (bwd_v[j]),
      .state_i (bwd_s[j]),
      .valid_o (bwd_v[j+1]),
      .state_o (bwd_s[j+1])
    );
  end

  assign done_o  = bwd_v[NUM_ROUNDS];
  assign out_x_o = bwd_s[NUM_ROUNDS].x;
  assign out_y_o = bwd_s[NUM_ROUNDS].y;

  // every accepted word comes out on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(2*NUM_ROUNDS) done_o)
    else $error("accepted word did not come out after fixed latency");

  // no result without a matching earlier start
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2*NUM_ROUNDS))
    else $error("result without matching start");

endmodule
